[rtl/pstf_pkg.sv]
// Package for the prioritized transmit frame cache: channel item types,
// the command passed from the front part to the back part, and fixed codes.
// Depends on nothing; the top, front and back files refer to it by scoped names.
package pstf_pkg;

  localparam int ID_W    = 29;
  localparam int FLAGS_W = 8;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int ROOM_W  = 5;
  localparam int KIND_W  = 2;
  localparam int SIDX_W  = 4;
  localparam int START_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_SENT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIO0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO2 = 2'd2;

  localparam logic [ID_W-1:0] PRIO0_RESET = 29'd128;
  localparam logic [ID_W-1:0] PRIO1_RESET = 29'd511;
  localparam logic [ID_W-1:0] PRIO2_RESET = 29'd1023;

  localparam logic [START_W-1:0] START_PRIO0 = 3'd0;
  localparam logic [START_W-1:0] START_PRIO1 = 3'd1;
  localparam logic [START_W-1:0] START_PRIO2 = 3'd2;
  localparam logic [START_W-1:0] START_HIGH  = 3'd4;

  localparam logic [ROOM_W-1:0] ROOM_LIMIT = 5'd16;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef struct packed {
    logic               op;
    logic [ID_W-1:0]    frame_id;
    logic [FLAGS_W-1:0] frame_flags;
    logic [LEN_W-1:0]   frame_len;
    logic [DATA_W-1:0]  frame_data;
    logic [ROOM_W-1:0]  writer_room;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SIDX_W-1:0]  slot_index;
    logic [ID_W-1:0]    out_id;
    logic [FLAGS_W-1:0] out_flags;
    logic [LEN_W-1:0]   out_len;
    logic [DATA_W-1:0]  out_data;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [FLAGS_W-1:0] flags;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
  } frame_t;

  typedef struct packed {
    logic               op;
    logic [START_W-1:0] start;
    logic [ROOM_W-1:0]  room;
    frame_t             frame;
  } cmd_t;

endpackage

[rtl/priority_slotted_tx_frame_cache_top.sv]
// Top level of the prioritized transmit frame cache: front classifier,
// command queue, back sequencer and result queue.
// Depends on pstf_pkg, pstf_fifo, pstf_front and pstf_back.
//
//   Channel  Ports                               Transaction
//   input    in_push, in_full, in_item           push && !full
//   result   out_pop, out_empty, out_item        pop && !empty
//   config   cfg_we, cfg_index, cfg_wdata        cfg_we high
//
// Steps: the back sequencer takes a command, searches for a slot, stores
// the frame, and for each frame sent reads the slot memory and then pushes
// the result; a full cache adds a second search and the step that closes
// the retry drain. A drain-only transaction takes the command and sends its
// frames the same way, or goes back to idle when it sends nothing. The one
// sequencer does these steps one after another.
// Reset is synchronous, active low, and clears all pending slots and queues.
// Either side may stall: the two-entry queues let the front accept while the
// back works, and the back waits whenever the result queue is full.
module priority_slotted_tx_frame_cache_top #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pstf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pstf_pkg::ID_W-1:0]          cfg_wdata,
  input  logic                               in_push,
  input  pstf_pkg::in_item_t                 in_item,
  output logic                               in_full,
  input  logic                               out_pop,
  output pstf_pkg::out_item_t                out_item,
  output logic                               out_empty
);

  logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
  pstf_pkg::cmd_t       cmd_in, cmd_out;
  logic                 res_push, res_full;
  pstf_pkg::out_item_t  res_data;

  // The front classifies each item as it is accepted; thresholds must only be
  // written while the block is idle, which the front itself does not enforce.
  pstf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full)
  );

  // Command queue between the front and the back.
  pstf_fifo #(
    .WIDTH ($bits(pstf_pkg::cmd_t)),
    .DEPTH (pstf_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  // The back owns the slots and produces every result in order.
  pstf_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Result queue: the oldest result sits on out_item while out_empty is low.
  pstf_fifo #(
    .WIDTH ($bits(pstf_pkg::out_item_t)),
    .DEPTH (pstf_pkg::RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_item),
    .empty     (out_empty)
  );

  // The sequencer must never push a result into a full queue.
  a_no_res_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed while result queue full");

  // The sequencer must only take a command that is there.
  a_no_cmd_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // After a reset cycle no result is waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule

[rtl/pstf_fifo.sv]
// Small register queue used for the command queue and the result queue.
// Depends on nothing; width and depth come from the instantiating module.
module pstf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/pstf_front.sv]
// Front part: holds the priority threshold registers and turns each accepted
// input item into a command with its start slot and clamped writer room.
// Depends on pstf_pkg.
module pstf_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pstf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pstf_pkg::ID_W-1:0]            cfg_wdata,
  input  logic                                 in_push,
  input  pstf_pkg::in_item_t                   in_item,
  output logic                                 in_full,
  output logic                                 cmd_push,
  output pstf_pkg::cmd_t                       cmd_data,
  input  logic                                 cmd_full
);

  logic [pstf_pkg::ID_W-1:0] prio0_r, prio1_r, prio2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio0_r <= pstf_pkg::PRIO0_RESET;
      prio1_r <= pstf_pkg::PRIO1_RESET;
      prio2_r <= pstf_pkg::PRIO2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pstf_pkg::CFG_PRIO0: prio0_r <= cfg_wdata;
        pstf_pkg::CFG_PRIO1: prio1_r <= cfg_wdata;
        pstf_pkg::CFG_PRIO2: prio2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

  always_comb begin
    cmd_data.op          = in_item.op;
    cmd_data.frame.id    = in_item.frame_id;
    cmd_data.frame.flags = in_item.frame_flags;
    cmd_data.frame.len   = in_item.frame_len;
    cmd_data.frame.data  = in_item.frame_data;
    if (in_item.frame_id <= prio0_r) begin
      cmd_data.start = pstf_pkg::START_PRIO0;
    end else if (in_item.frame_id <= prio1_r) begin
      cmd_data.start = pstf_pkg::START_PRIO1;
    end else if (in_item.frame_id <= prio2_r) begin
      cmd_data.start = pstf_pkg::START_PRIO2;
    end else begin
      cmd_data.start = pstf_pkg::START_HIGH;
    end
    // The writer never takes more than the room limit in one step.
    if (in_item.writer_room > pstf_pkg::ROOM_LIMIT) begin
      cmd_data.room = pstf_pkg::ROOM_LIMIT;
    end else begin
      cmd_data.room = in_item.writer_room;
    end
  end

endmodule

[rtl/pstf_back.sv]
// Back part: slot pending bits, slot frame memory and the sequencer that
// stores a submitted frame, drains pending slots and emits result items.
// Depends on pstf_pkg.
module pstf_back #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_empty,
  input  pstf_pkg::cmd_t         cmd_data,
  output logic                   cmd_pop,
  input  logic                   res_full,
  output logic                   res_push,
  output pstf_pkg::out_item_t    res_data
);

  localparam int SW = $clog2(SLOT_COUNT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIND  = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_SEND  = 3'd4;
  localparam logic [2:0] ST_OVF   = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  pstf_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [pstf_pkg::ROOM_W-1:0]   room_r, room_nxt, room_dec;
  logic                          retry_r, retry_nxt;
  logic                          final_r, final_nxt;
  logic                          last_r, last_nxt;
  logic [SW-1:0]                 slot_r, slot_nxt;
  logic [SLOT_COUNT-1:0]         pend_r, pend_nxt;

  pstf_pkg::frame_t              slot_mem [SLOT_COUNT];
  pstf_pkg::frame_t              rd_r;
  logic                          mem_we, mem_re;

  logic [SLOT_COUNT-1:0]         free_mask, other_pend;
  logic [SW-1:0]                 first_free, first_pend;
  logic                          free_hit, pend_hit;

  // Priority encoders: lowest free slot at or above the start, lowest
  // pending slot.
  always_comb begin
    free_mask  = ~pend_r & ({SLOT_COUNT{1'b1}} << SW'(cmd_r.start));
    first_free = '0;
    free_hit   = 1'b0;
    first_pend = '0;
    pend_hit   = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        first_free = SW'(i);
        free_hit   = 1'b1;
      end
      if (pend_r[i]) begin
        first_pend = SW'(i);
        pend_hit   = 1'b1;
      end
    end
    other_pend             = pend_r;
    other_pend[first_pend] = 1'b0;
    room_dec               = room_r - pstf_pkg::ROOM_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    room_nxt  = room_r;
    retry_nxt = retry_r;
    final_nxt = final_r;
    last_nxt  = last_r;
    slot_nxt  = slot_r;
    pend_nxt  = pend_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;

    res_data.kind       = pstf_pkg::KIND_SENT;
    res_data.slot_index = pstf_pkg::SIDX_W'(slot_r);
    res_data.out_id     = rd_r.id;
    res_data.out_flags  = rd_r.flags;
    res_data.out_len    = rd_r.len;
    res_data.out_data   = rd_r.data;
    res_data.last       = last_r;

    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_data;
          room_nxt  = cmd_data.room;
          retry_nxt = 1'b0;
          if (cmd_data.op == pstf_pkg::OP_DRAIN) begin
            final_nxt = 1'b1;
            state_nxt = ST_DRAIN;
          end else begin
            final_nxt = 1'b0;
            state_nxt = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        if (free_hit) begin
          slot_nxt  = first_free;
          state_nxt = ST_STORE;
        end else if (!retry_r) begin
          // Cache full: drain once with the same room budget, then retry.
          retry_nxt = 1'b1;
          final_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_OVF;
        end
      end
      ST_STORE: begin
        res_data.kind       = pstf_pkg::KIND_ACCEPT;
        res_data.out_id     = cmd_r.frame.id;
        res_data.out_flags  = cmd_r.frame.flags;
        res_data.out_len    = cmd_r.frame.len;
        res_data.out_data   = cmd_r.frame.data;
        res_data.last       = (room_r == '0);
        if (!res_full) begin
          res_push         = 1'b1;
          mem_we           = 1'b1;
          pend_nxt[slot_r] = 1'b1;
          final_nxt        = 1'b1;
          state_nxt        = (room_r == '0) ? ST_IDLE : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (room_r == '0 || !pend_hit) begin
          state_nxt = final_r ? ST_IDLE : ST_FIND;
        end else begin
          mem_re               = 1'b1;
          pend_nxt[first_pend] = 1'b0;
          room_nxt             = room_dec;
          slot_nxt             = first_pend;
          last_nxt             = final_r && (room_dec == '0 || other_pend == '0);
          state_nxt            = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = last_r ? ST_IDLE : ST_DRAIN;
        end
      end
      ST_OVF: begin
        res_data.kind       = pstf_pkg::KIND_OVERFLOW;
        res_data.slot_index = '0;
        res_data.out_id     = cmd_r.frame.id;
        res_data.out_flags  = cmd_r.frame.flags;
        res_data.out_len    = cmd_r.frame.len;
        res_data.out_data   = cmd_r.frame.data;
        res_data.last       = 1'b1;
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
      retry_r <= 1'b0;
      final_r <= 1'b0;
      last_r  <= 1'b0;
      room_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      retry_r <= retry_nxt;
      final_r <= final_nxt;
      last_r  <= last_nxt;
      room_r  <= room_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[slot_r] <= cmd_r.frame;
    end
    if (mem_re) begin
      rd_r <= slot_mem[first_pend];
    end
  end

endmodule
